// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// property that must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfcr_pkg
// types, constants and the crc helper of the framed crc16 receiver
// ----------------------------------------------------------------------------
`default_nettype none

package mfcr_pkg;

   // widths
   localparam int LENGTH_BITS_DEF = 19;
   localparam int TIMEOUT_W       = 16;
   localparam int MAX_LEN_W       = 19;
   localparam int LEN_FIELD_W     = 32;
   localparam int CRC_W           = 16;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 19;
   localparam int COUNT_W         = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_TO   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIELD_TO    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ERRTRAIL_TO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BODY_TO     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LENGTH  = 3'd4;

   // register reset values
   localparam logic [TIMEOUT_W-1:0] HEADER_TO_RST   = 16'd8000;
   localparam logic [TIMEOUT_W-1:0] FIELD_TO_RST    = 16'd3000;
   localparam logic [TIMEOUT_W-1:0] ERRTRAIL_TO_RST = 16'd2000;
   localparam logic [TIMEOUT_W-1:0] BODY_TO_RST     = 16'd12000;
   localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RST  = 19'd400000;

   // frame constants
   localparam logic [31:0]       MAGIC_DATA  = 32'h5056_4943;
   localparam logic [31:0]       MAGIC_ERR   = 32'h5056_4945;
   localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;
   localparam logic [TIMEOUT_W-1:0] TICKS_MAX = 16'hFFFF;
   localparam logic [COUNT_W-1:0] WINDOW_FULL = 3'd4;
   localparam logic [COUNT_W-1:0] LEN_BYTES   = 3'd4;
   localparam logic [COUNT_W-1:0] FIELD_BYTES = 3'd6;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HUNT,
      PH_FIELDS,
      PH_ERRTRAIL,
      PH_BODY,
      PH_REPORT
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_HEADER_TO   = 3'd1,
      ST_LENGTH_TO   = 3'd2,
      ST_BAD_LENGTH  = 3'd3,
      ST_CAMERA_ERR  = 3'd4,
      ST_ERRTRAIL_TO = 3'd5,
      ST_BODY_TO     = 3'd6,
      ST_CRC_BAD     = 3'd7
   } status_type;

   localparam logic KIND_BODY   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] header_to;
      logic [TIMEOUT_W-1:0] field_to;
      logic [TIMEOUT_W-1:0] errtrail_to;
      logic [TIMEOUT_W-1:0] body_to;
      logic [MAX_LEN_W-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       body_byte;
      status_type       status;
      logic [CRC_W-1:0] frame_crc;
   } rsp_type;

   // crc-16/modbus update over one byte, lsb first
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/magic_framed_crc16_receiver.sv =====
// ----------------------------------------------------------------------------
// magic_framed_crc16_receiver
// length-prefixed frame receiver with magic search and crc-16/modbus check
// ----------------------------------------------------------------------------
// usage:
//  - req channel carries one word per start, received byte or 1 ms tick;
//    a word is taken when req_valid is high and req_stall is low
//  - rsp channel returns at most one word per request word: a passed-through
//    body byte or a final status, with length and crc when ok; taken when
//    rsp_valid is high and rsp_stall is low
//  - csr channel writes the timeout and max length registers; csr_ready is
//    always high, writes belong to idle periods
//  - path: a request word is held in the input register, then processed
//    and written into the result register, which drives the rsp ports
//  - throughput: one word per cycle when not stalled; the frame state update
//    is the single pass between input and result register
//  - a stalled result register holds its word and stops the input register;
//    req_stall rises once the input register is full and cannot drain
//  - reset puts the receiver in idle with the register defaults; bytes and
//    ticks are ignored until a start word arms it
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module magic_framed_crc16_receiver #(
   parameter int LENGTH_BITS = mfcr_pkg::LENGTH_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [7:0]                        req_data_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [7:0]                        rsp_body_byte,
   output logic [2:0]                        rsp_status,
   output logic [LENGTH_BITS-1:0]            rsp_frame_length,
   output logic [15:0]                       rsp_frame_crc,
   // csr write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mfcr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mfcr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mfcr_pkg::*;

   cfg_type                 cfg;
   logic                    in_valid_ff, in_valid_in;
   op_type                  in_op_ff;
   logic [7:0]              in_byte_ff;
   logic                    adv;
   logic                    req_take;
   logic                    res_valid;
   rsp_type                 res;
   logic [LENGTH_BITS-1:0]  res_length;
   logic                    rsp_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;
   logic [LENGTH_BITS-1:0]  rsp_length_ff;

   // configuration registers
   mfcr_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register advances whenever the result register can take a word
   assign adv       = in_valid_ff & ~(rsp_valid_ff & rsp_stall);
   assign req_stall = in_valid_ff & ~adv;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (adv)  in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= op_type'(req_op);
         in_byte_ff <= req_data_byte;
      end
   end

   // frame state machine
   mfcr_frame_ctrl #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (adv),
      .item_op    (in_op_ff),
      .item_byte  (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res),
      .res_length (res_length)
   );

   // result register
   assign rsp_load = adv & res_valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)         rsp_valid_in = 1'b1;
      else if (!rsp_stall)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff        <= res;
         rsp_length_ff <= res_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_body_byte    = rsp_ff.body_byte;
   assign rsp_status       = rsp_ff.status;
   assign rsp_frame_length = rsp_length_ff;
   assign rsp_frame_crc    = rsp_ff.frame_crc;

   // checks
   `ASSERT_SAME(a_no_adv_on_stall, rsp_valid_ff && rsp_stall, !adv, "word taken under stall")
   `ASSERT_NEXT(a_held_word_kept, in_valid_ff && !adv, in_valid_ff, "held request word was lost")
   `ASSERT_NEXT(a_no_repeat, rsp_valid_ff && !rsp_stall && !rsp_load, !rsp_valid_ff, "word repeated")

endmodule

`default_nettype wire

// ===== rtl/mfcr_csr_regs.sv =====
// ----------------------------------------------------------------------------
// mfcr_csr_regs
// timeout and maximum length registers behind the csr write channel
// ----------------------------------------------------------------------------
`default_nettype none

module mfcr_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfcr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mfcr_pkg::cfg_type                   cfg
);
   import mfcr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // decode the index, unknown indexes leave the registers alone
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            REG_HEADER_TO:   cfg_in.header_to   = csr_wdata[TIMEOUT_W-1:0];
            REG_FIELD_TO:    cfg_in.field_to    = csr_wdata[TIMEOUT_W-1:0];
            REG_ERRTRAIL_TO: cfg_in.errtrail_to = csr_wdata[TIMEOUT_W-1:0];
            REG_BODY_TO:     cfg_in.body_to     = csr_wdata[TIMEOUT_W-1:0];
            REG_MAX_LENGTH:  cfg_in.max_length  = csr_wdata[MAX_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_to   <= HEADER_TO_RST;
         cfg_ff.field_to    <= FIELD_TO_RST;
         cfg_ff.errtrail_to <= ERRTRAIL_TO_RST;
         cfg_ff.body_to     <= BODY_TO_RST;
         cfg_ff.max_length  <= MAX_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/mfcr_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfcr_frame_ctrl
// frame state machine: magic hunt, header fields, body crc and status report
// ----------------------------------------------------------------------------
`default_nettype none

module mfcr_frame_ctrl #(
   parameter int LENGTH_BITS = mfcr_pkg::LENGTH_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mfcr_pkg::cfg_type            cfg,
   input  logic                         item_valid,
   input  mfcr_pkg::op_type             item_op,
   input  logic [7:0]                   item_byte,
   output logic                         res_valid,
   output mfcr_pkg::rsp_type            res,
   output logic [LENGTH_BITS-1:0]       res_length
);
   import mfcr_pkg::*;

   phase_type               phase_ff,   phase_in;
   logic [31:0]             window_ff,  window_in;
   logic [COUNT_W-1:0]      fill_ff,    fill_in;
   logic [COUNT_W-1:0]      count_ff,   count_in;
   logic [LEN_FIELD_W-1:0]  length_ff,  length_in;
   logic [CRC_W-1:0]        exp_crc_ff, exp_crc_in;
   logic [CRC_W-1:0]        run_crc_ff, run_crc_in;
   logic [LENGTH_BITS-1:0]  left_ff,    left_in;
   logic [TIMEOUT_W-1:0]    elapsed_ff, elapsed_in;

   logic [TIMEOUT_W-1:0]    elapsed_inc;
   logic [TIMEOUT_W-1:0]    limit;
   status_type              to_status;
   logic                    tick_expired;
   logic [31:0]             window_shift;
   logic [COUNT_W-1:0]      fill_inc;
   logic                    hit_data;
   logic                    hit_err;
   logic [COUNT_W-1:0]      count_inc;
   logic                    fields_done;
   logic [LEN_FIELD_W-1:0]  length_upd;
   logic [CRC_W-1:0]        exp_crc_upd;
   logic                    bad_length;
   logic [LENGTH_BITS-1:0]  left_dec;
   logic [CRC_W-1:0]        crc_next;
   logic                    crc_match;

   // idle tick count, saturating
   assign elapsed_inc = (elapsed_ff == TICKS_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // timeout limit and status of the current phase
   always_comb begin
      case (phase_ff)
         PH_HUNT: begin
            limit     = cfg.header_to;
            to_status = ST_HEADER_TO;
         end
         PH_FIELDS: begin
            limit     = cfg.field_to;
            to_status = ST_LENGTH_TO;
         end
         PH_ERRTRAIL: begin
            limit     = cfg.errtrail_to;
            to_status = ST_ERRTRAIL_TO;
         end
         default: begin
            limit     = cfg.body_to;
            to_status = ST_BODY_TO;
         end
      endcase
   end
   assign tick_expired = elapsed_inc > limit;

   // magic window
   assign window_shift = {window_ff[23:0], item_byte};
   assign fill_inc     = (fill_ff == WINDOW_FULL) ? fill_ff : fill_ff + 1'b1;
   assign hit_data     = (fill_inc == WINDOW_FULL) && (window_shift == MAGIC_DATA);
   assign hit_err      = (fill_inc == WINDOW_FULL) && (window_shift == MAGIC_ERR);

   // header fields: four length bytes then two crc bytes, big-endian
   assign count_inc   = count_ff + 1'b1;
   assign fields_done = count_inc >= FIELD_BYTES;
   assign length_upd  = (count_ff < LEN_BYTES) ? {length_ff[LEN_FIELD_W-9:0], item_byte}
                                               : length_ff;
   assign exp_crc_upd = (count_ff < LEN_BYTES) ? exp_crc_ff
                                               : {exp_crc_ff[CRC_W-9:0], item_byte};
   assign bad_length  = (length_upd == '0)
                      || (length_upd > LEN_FIELD_W'(cfg.max_length))
                      || ((length_upd >> LENGTH_BITS) != '0);

   // body
   assign left_dec  = left_ff - 1'b1;
   assign crc_next  = crc16_byte(run_crc_ff, item_byte);
   assign crc_match = run_crc_ff == exp_crc_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item_valid) begin
         if (phase_ff == PH_REPORT) begin
            phase_in = (item_op == OP_START) ? PH_HUNT : PH_IDLE;
         end else if (item_op == OP_START) begin
            phase_in = PH_HUNT;
         end else if (phase_ff != PH_IDLE) begin
            case (item_op)
               OP_TICK: begin
                  if (tick_expired) phase_in = PH_IDLE;
               end
               OP_BYTE: begin
                  case (phase_ff)
                     PH_HUNT: begin
                        if (hit_data)     phase_in = PH_FIELDS;
                        else if (hit_err) phase_in = PH_ERRTRAIL;
                     end
                     PH_FIELDS: begin
                        if (fields_done) phase_in = bad_length ? PH_IDLE : PH_BODY;
                     end
                     PH_ERRTRAIL: begin
                        if (fields_done) phase_in = PH_IDLE;
                     end
                     PH_BODY: begin
                        if (left_dec == '0) phase_in = PH_REPORT;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
      end
   end

   // datapath updates and result word
   always_comb begin
      window_in  = window_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      exp_crc_in = exp_crc_ff;
      run_crc_in = run_crc_ff;
      left_in    = left_ff;
      elapsed_in = elapsed_ff;
      res_valid  = 1'b0;
      res        = '0;
      res_length = '0;
      if (item_valid) begin
         if (phase_ff == PH_REPORT || item_op == OP_START) begin
            // final status of a finished body
            if (phase_ff == PH_REPORT) begin
               res_valid  = 1'b1;
               res.kind   = KIND_STATUS;
               res.status = crc_match ? ST_OK : ST_CRC_BAD;
               if (crc_match) begin
                  res.frame_crc = exp_crc_ff;
                  res_length    = length_ff[LENGTH_BITS-1:0];
               end
            end
            // arm
            if (item_op == OP_START) begin
               window_in  = '0;
               fill_in    = '0;
               count_in   = '0;
               length_in  = '0;
               exp_crc_in = '0;
               run_crc_in = CRC_INIT;
               left_in    = '0;
               elapsed_in = '0;
            end
         end else if (phase_ff != PH_IDLE) begin
            case (item_op)
               OP_TICK: begin
                  elapsed_in = elapsed_inc;
                  if (tick_expired) begin
                     res_valid  = 1'b1;
                     res.kind   = KIND_STATUS;
                     res.status = to_status;
                  end
               end
               OP_BYTE: begin
                  if (phase_ff == PH_HUNT) begin
                     window_in = window_shift;
                     fill_in   = fill_inc;
                     if (hit_data || hit_err) begin
                        count_in   = '0;
                        elapsed_in = '0;
                     end
                  end else begin
                     elapsed_in = '0;
                     case (phase_ff)
                        PH_FIELDS: begin
                           count_in   = count_inc;
                           length_in  = length_upd;
                           exp_crc_in = exp_crc_upd;
                           if (fields_done) begin
                              if (bad_length) begin
                                 res_valid  = 1'b1;
                                 res.kind   = KIND_STATUS;
                                 res.status = ST_BAD_LENGTH;
                              end else begin
                                 left_in    = length_upd[LENGTH_BITS-1:0];
                                 run_crc_in = CRC_INIT;
                              end
                           end
                        end
                        PH_ERRTRAIL: begin
                           count_in = count_inc;
                           if (fields_done) begin
                              res_valid  = 1'b1;
                              res.kind   = KIND_STATUS;
                              res.status = ST_CAMERA_ERR;
                           end
                        end
                        PH_BODY: begin
                           run_crc_in    = crc_next;
                           left_in       = left_dec;
                           res_valid     = 1'b1;
                           res.kind      = KIND_BODY;
                           res.body_byte = item_byte;
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         fill_ff    <= '0;
         count_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // frame payload, always initialised by start before use
   always_ff @(posedge clock) begin
      window_ff  <= window_in;
      length_ff  <= length_in;
      exp_crc_ff <= exp_crc_in;
      run_crc_ff <= run_crc_in;
      left_ff    <= left_in;
   end

endmodule

`default_nettype wire
